>>> sv/binary_image_thinning_unit_macros.svh
// Assertion macros for the binary image thinning unit.
`ifndef BINARY_IMAGE_THINNING_UNIT_MACROS_SVH
`define BINARY_IMAGE_THINNING_UNIT_MACROS_SVH

// Implication within the same cycle.
`define BITU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication in the next cycle.
`define BITU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/bitu_pkg.sv
// Shared request codes, register indexes and neighbor count bounds of the binary image thinning unit.
package bitu_pkg;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_RUN   = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ITER   = 2'd2;

  localparam int NB_MIN = 2;
  localparam int NB_MAX = 6;

endpackage

>>> sv/binary_image_thinning_unit.sv
// Zhang-Suen thinning engine on a frame held in block memory.
// A pixel write or read returns its result beat in the cycle after acceptance.
// A run repeats iteration_count passes of two half-passes, each a copy sweep and a
// neighbor fetch per pixel through the one read port of the mask memory.
// The result beat of a run follows the last write of the last half-pass; busy is high meanwhile.
// Reset is synchronous and restores the register defaults; memory contents stay undefined.
module binary_image_thinning_unit #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_req_type,
  input  logic [5:0] in_row,
  input  logic [5:0] in_col,
  input  logic [7:0] in_pixel_value,
  output logic       out_valid,
  output logic [7:0] out_read_value,
  output logic       out_address_error,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);
  import bitu_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DWW   = ($clog2(MAX_WIDTH + 1) > 7) ? $clog2(MAX_WIDTH + 1) : 7;
  localparam int DWH   = ($clog2(MAX_HEIGHT + 1) > 7) ? $clog2(MAX_HEIGHT + 1) : 7;

  typedef enum logic [1:0] {ST_IDLE, ST_COPY, ST_DRAIN, ST_DECIDE} state_t;

  state_t       state_r;
  logic [6:0]   frame_width_r;
  logic [6:0]   frame_height_r;
  logic [3:0]   iter_r;
  logic [3:0]   pass_r;
  logic         phase_r;
  logic [RW-1:0] r_r;
  logic [CW-1:0] c_r;
  logic [3:0]   k_r;
  logic [8:0]   nb_r;
  logic         nb_in_r;
  logic         cp_vld_r;
  logic [AW-1:0] cp_addr_r;
  logic         out_valid_r;
  logic         out_rd_r;
  logic         out_err_r;

  logic [7:0]   pix_mem [DEPTH];
  logic         mask_mem [DEPTH];
  logic [7:0]   pix_rd_r;
  logic         mask_rd_r;

  logic [DWW-1:0] w;
  logic [DWH-1:0] h;
  logic           addr_bad;
  logic           last_pix;
  logic [AW-1:0]  req_addr;
  logic [AW-1:0]  cur_addr;
  logic [AW-1:0]  nb_addr;
  logic           nb_in;
  logic [RW-1:0]  nr;
  logic [CW-1:0]  nc;
  logic           up_ok, dn_ok, lf_ok, rt_ok;
  logic [8:0]     nbv;
  logic [3:0]     cnt;
  logic [3:0]     trans;
  logic           keep_dir;
  logic           del;
  logic           pix_we;
  logic [AW-1:0]  pix_waddr;
  logic [7:0]     pix_wdata;
  logic [AW-1:0]  pix_raddr;
  logic           accept;

  function automatic logic [AW-1:0] mk_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    mk_addr = AW'(r) * AW'(MAX_WIDTH) + AW'(c);
  endfunction

  always_comb begin
    if (frame_width_r == 7'd0) begin
      w = DWW'(1);
    end else if (DWW'(frame_width_r) > DWW'(MAX_WIDTH)) begin
      w = DWW'(MAX_WIDTH);
    end else begin
      w = DWW'(frame_width_r);
    end
    if (frame_height_r == 7'd0) begin
      h = DWH'(1);
    end else if (DWH'(frame_height_r) > DWH'(MAX_HEIGHT)) begin
      h = DWH'(MAX_HEIGHT);
    end else begin
      h = DWH'(frame_height_r);
    end
  end

  assign accept   = start && !busy;
  assign addr_bad = (DWH'(in_row) >= h) || (DWW'(in_col) >= w);
  assign req_addr = AW'(in_row) * AW'(MAX_WIDTH) + AW'(in_col);
  assign cur_addr = mk_addr(r_r, c_r);
  assign last_pix = (DWH'(r_r) == h - DWH'(1)) && (DWW'(c_r) == w - DWW'(1));

  assign up_ok = (r_r != '0);
  assign dn_ok = (DWH'(r_r) + DWH'(1) < h);
  assign lf_ok = (c_r != '0);
  assign rt_ok = (DWW'(c_r) + DWW'(1) < w);

  always_comb begin
    nr    = r_r;
    nc    = c_r;
    nb_in = 1'b1;
    case (k_r)
      4'd0: begin nr = r_r - 1'b1; nb_in = up_ok; end
      4'd1: begin nr = r_r - 1'b1; nc = c_r + 1'b1; nb_in = up_ok && rt_ok; end
      4'd2: begin nc = c_r + 1'b1; nb_in = rt_ok; end
      4'd3: begin nr = r_r + 1'b1; nc = c_r + 1'b1; nb_in = dn_ok && rt_ok; end
      4'd4: begin nr = r_r + 1'b1; nb_in = dn_ok; end
      4'd5: begin nr = r_r + 1'b1; nc = c_r - 1'b1; nb_in = dn_ok && lf_ok; end
      4'd6: begin nc = c_r - 1'b1; nb_in = lf_ok; end
      4'd7: begin nr = r_r - 1'b1; nc = c_r - 1'b1; nb_in = up_ok && lf_ok; end
      default: begin nb_in = 1'b1; end
    endcase
  end
  assign nb_addr = mk_addr(nr, nc);

  always_comb begin
    nbv    = nb_r;
    nbv[8] = nb_in_r && mask_rd_r;
    cnt    = '0;
    trans  = '0;
    for (int k = 0; k < 8; k++) begin
      cnt = cnt + 4'(nbv[k]);
      if (nbv[(k + 1) % 8] && !nbv[k]) begin
        trans = trans + 4'd1;
      end
    end
    if (!phase_r) begin
      keep_dir = nbv[2] && nbv[4] && (nbv[0] || nbv[6]);
    end else begin
      keep_dir = nbv[0] && nbv[6] && (nbv[2] || nbv[4]);
    end
    del = nbv[8] && (cnt >= 4'(NB_MIN)) && (cnt <= 4'(NB_MAX)) && (trans == 4'd1) && !keep_dir;
  end

  always_comb begin
    pix_we    = 1'b0;
    pix_waddr = req_addr;
    pix_wdata = in_pixel_value;
    pix_raddr = req_addr;
    if (state_r == ST_IDLE) begin
      pix_we = accept && (in_req_type == REQ_WRITE) && !addr_bad;
    end else begin
      pix_raddr = cur_addr;
      if (state_r == ST_DECIDE && k_r == 4'd9 && del) begin
        pix_we    = 1'b1;
        pix_waddr = cur_addr;
        pix_wdata = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_we) begin
      pix_mem[pix_waddr] <= pix_wdata;
    end
    pix_rd_r <= pix_mem[pix_raddr];
    if (cp_vld_r) begin
      mask_mem[cp_addr_r] <= (pix_rd_r != 8'd0);
    end
    mask_rd_r <= mask_mem[nb_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      frame_width_r  <= 7'd64;
      frame_height_r <= 7'd64;
      iter_r         <= 4'd1;
      pass_r         <= '0;
      phase_r        <= 1'b0;
      r_r            <= '0;
      c_r            <= '0;
      k_r            <= '0;
      cp_vld_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      out_rd_r       <= 1'b0;
      out_err_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      cp_vld_r    <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  frame_width_r  <= cfg_data;
          CFG_HEIGHT: frame_height_r <= cfg_data;
          CFG_ITER:   iter_r         <= cfg_data[3:0];
          default:    ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            out_rd_r  <= (in_req_type == REQ_READ) && !addr_bad;
            out_err_r <= ((in_req_type == REQ_READ) || (in_req_type == REQ_WRITE)) && addr_bad;
            if (in_req_type == REQ_RUN && iter_r != 4'd0) begin
              state_r <= ST_COPY;
              pass_r  <= '0;
              phase_r <= 1'b0;
              r_r     <= '0;
              c_r     <= '0;
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        ST_COPY: begin
          cp_vld_r  <= 1'b1;
          cp_addr_r <= cur_addr;
          if (last_pix) begin
            state_r <= ST_DRAIN;
            r_r     <= '0;
            c_r     <= '0;
          end else if (DWW'(c_r) == w - DWW'(1)) begin
            c_r <= '0;
            r_r <= r_r + 1'b1;
          end else begin
            c_r <= c_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_DECIDE;
          k_r     <= '0;
        end
        ST_DECIDE: begin
          nb_in_r <= nb_in;
          if (k_r != 4'd0) begin
            nb_r[k_r - 4'd1] <= nb_in_r && mask_rd_r;
          end
          if (k_r == 4'd9) begin
            k_r <= '0;
            if (last_pix) begin
              r_r     <= '0;
              c_r     <= '0;
              phase_r <= !phase_r;
              if (phase_r && (pass_r + 4'd1 == iter_r)) begin
                state_r     <= ST_IDLE;
                out_valid_r <= 1'b1;
              end else begin
                state_r <= ST_COPY;
                if (phase_r) begin
                  pass_r <= pass_r + 4'd1;
                end
              end
            end else if (DWW'(c_r) == w - DWW'(1)) begin
              c_r <= '0;
              r_r <= r_r + 1'b1;
            end else begin
              c_r <= c_r + 1'b1;
            end
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_read_value    = out_rd_r ? pix_rd_r : 8'd0;
  assign out_address_error = out_err_r;

`include "binary_image_thinning_unit_macros.svh"

  `BITU_ASSERT_NOW(a_no_beat_busy, clk, rst_n, out_valid_r, !busy)
  `BITU_ASSERT_NOW(a_run_end_beat, clk, rst_n, $fell(busy), out_valid_r && !out_err_r)
  `BITU_ASSERT_NEXT(a_run_starts, clk, rst_n,
    accept && (in_req_type == REQ_RUN) && (iter_r != 4'd0), busy && !out_valid_r)
  `BITU_ASSERT_NOW(a_k_bound, clk, rst_n, state_r == ST_DECIDE, k_r <= 4'd9)

endmodule

>>> dv/binary_image_thinning_unit_tb.sv
// Self-checking testbench for the binary image thinning unit: pixel traffic and thinning runs.
module binary_image_thinning_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bitu_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;

  typedef struct packed {
    logic [7:0] value;
    logic       addr_err;
  } outcome_t;

  class thin_scoreboard;
    logic [7:0] pixels [4096];
    bit fg_copy [4096];
    int unsigned width_reg = 64;
    int unsigned height_reg = 64;
    int unsigned passes = 1;
    outcome_t expected_q [$];
    int errors = 0;
    int n_writes = 0;
    int n_reads = 0;
    int n_runs = 0;
    int n_flagged = 0;

    function int unsigned clamp_dim(int unsigned v);
      if (v == 0) return 1;
      if (v > 64) return 64;
      return v;
    endfunction

    function void set_reg(logic [1:0] idx, logic [6:0] d);
      case (idx)
        CFG_WIDTH: width_reg = 32'(d);
        CFG_HEIGHT: height_reg = 32'(d);
        CFG_ITER: passes = 32'(d[3:0]);
        default: ;
      endcase
    endfunction

    function bit fg_at(int r, int c, int h, int w);
      if (r < 0 || r >= h || c < 0 || c >= w) return 0;
      return fg_copy[r * 64 + c];
    endfunction

    function void sweep(bit second, int h, int w);
      int dr [8];
      int dc [8];
      bit nb [8];
      int cnt;
      int trans;
      bit keep;
      dr = '{-1, -1, 0, 1, 1, 1, 0, -1};
      dc = '{0, 1, 1, 1, 0, -1, -1, -1};
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++)
          fg_copy[r * 64 + c] = (pixels[r * 64 + c] != 8'd0);
      for (int r = 0; r < h; r++) begin
        for (int c = 0; c < w; c++) begin
          if (!fg_copy[r * 64 + c]) continue;
          cnt = 0;
          trans = 0;
          for (int k = 0; k < 8; k++) begin
            nb[k] = fg_at(r + dr[k], c + dc[k], h, w);
            cnt += nb[k];
          end
          for (int k = 0; k < 8; k++)
            if (nb[(k + 1) % 8] && !nb[k]) trans++;
          if (cnt < NB_MIN || cnt > NB_MAX || trans != 1) continue;
          if (!second) keep = nb[2] && nb[4] && (nb[0] || nb[6]);
          else keep = nb[0] && nb[6] && (nb[2] || nb[4]);
          if (!keep) pixels[r * 64 + c] = 8'd0;
        end
      end
    endfunction

    function void note_request(logic [1:0] req, logic [5:0] row, logic [5:0] col,
                               logic [7:0] val);
      outcome_t o;
      int unsigned w;
      int unsigned h;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      o = '0;
      if (req == REQ_WRITE || req == REQ_READ) begin
        if (row >= h || col >= w) begin
          o.addr_err = 1'b1;
          n_flagged++;
        end else if (req == REQ_WRITE) begin
          pixels[row * 64 + col] = val;
          n_writes++;
        end else begin
          o.value = pixels[row * 64 + col];
          n_reads++;
        end
      end else if (req == REQ_RUN) begin
        n_runs++;
        for (int n = 0; n < passes; n++) begin
          sweep(1'b0, h, w);
          sweep(1'b1, h, w);
        end
      end
      expected_q = {expected_q, o};
    endfunction

    function void check_result(logic [7:0] value, logic addr_err);
      outcome_t o;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat value=%0h addr_err=%0b", $time, value, addr_err);
        errors++;
        return;
      end
      o = expected_q.pop_front();
      if (value !== o.value) begin
        $display("%0t: read_value expected %0h actual %0h", $time, o.value, value);
        errors++;
      end
      if (addr_err !== o.addr_err) begin
        $display("%0t: address_error expected %0b actual %0b", $time, o.addr_err, addr_err);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_req_type;
  logic [5:0] in_row;
  logic [5:0] in_col;
  logic [7:0] in_pixel_value;
  logic out_valid;
  logic [7:0] out_read_value;
  logic out_address_error;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;

  thin_scoreboard sb = new();
  int idle_pct = 0;
  int items_sent = 0;

  binary_image_thinning_unit u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_row(in_row),
    .in_col(in_col),
    .in_pixel_value(in_pixel_value),
    .out_valid(out_valid),
    .out_read_value(out_read_value),
    .out_address_error(out_address_error),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_result(out_read_value, out_address_error);
  end

  initial begin
    #20ms;
    $display("binary_image_thinning_unit_tb failed");
    $finish;
  end

  task automatic send_item(input logic [1:0] rq, input logic [5:0] r, input logic [5:0] c,
                           input logic [7:0] v);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_req_type <= rq;
    in_row <= r;
    in_col <= c;
    in_pixel_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(rq, r, c, v);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [6:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup_frame(input logic [6:0] w, input logic [6:0] h, input logic [6:0] it);
    int unsigned ew;
    int unsigned eh;
    wait_idle();
    cfg_write(CFG_WIDTH, w);
    cfg_write(CFG_HEIGHT, h);
    cfg_write(CFG_ITER, it);
    ew = sb.clamp_dim(32'(w));
    eh = sb.clamp_dim(32'(h));
    for (int r = 0; r < eh; r++)
      for (int c = 0; c < ew; c++)
        send_item(REQ_WRITE, 6'(r), 6'(c),
                  ($urandom_range(99) < 60) ? 8'($urandom_range(1, 255)) : 8'd0);
  endtask

  task automatic random_items(input int count, input bit allow_run);
    int unsigned w;
    int unsigned h;
    int k;
    logic [5:0] r;
    logic [5:0] c;
    w = sb.clamp_dim(sb.width_reg);
    h = sb.clamp_dim(sb.height_reg);
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      r = 6'($urandom_range(h - 1));
      c = 6'($urandom_range(w - 1));
      if ((k >= 35 && k < 45) || (k >= 70 && k < 78)) begin
        if (w < 64 && (h == 64 || $urandom_range(1))) begin
          c = 6'($urandom_range(w, 63));
          r = 6'($urandom_range(63));
        end else if (h < 64) begin
          r = 6'($urandom_range(h, 63));
          c = 6'($urandom_range(63));
        end
      end
      if (k < 45) send_item(REQ_WRITE, r, c, 8'($urandom_range(255)));
      else if (k < 78) send_item(REQ_READ, r, c, 8'($urandom_range(255)));
      else if (k < 84 || !allow_run)
        send_item(REQ_NONE, 6'($urandom_range(63)), 6'($urandom_range(63)),
                  8'($urandom_range(255)));
      else send_item(REQ_RUN, 6'($urandom_range(63)), 6'($urandom_range(63)),
                     8'($urandom_range(255)));
    end
  endtask

  initial begin
    int phase_pct [4];
    int guard;
    phase_pct = '{0, 54, 31, 0};
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = REQ_WRITE;
    in_row = '0;
    in_col = '0;
    in_pixel_value = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    wait_idle();
    cfg_write(CFG_WIDTH, 7'd3);
    cfg_write(CFG_HEIGHT, 7'd3);
    cfg_write(CFG_ITER, 7'd1);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_item(REQ_WRITE, 6'(r), 6'(c), (r == 1 || c == 1) ? 8'hFF : 8'h01);
    send_item(REQ_READ, 6'd0, 6'd0, 8'h00);
    send_item(REQ_WRITE, 6'd63, 6'd63, 8'hFF);
    send_item(REQ_READ, 6'd3, 6'd0, 8'h00);
    send_item(REQ_READ, 6'd0, 6'd63, 8'h00);
    send_item(REQ_NONE, 6'd63, 6'd63, 8'hFF);
    send_item(REQ_RUN, 6'd0, 6'd0, 8'h00);
    send_item(REQ_READ, 6'd1, 6'd1, 8'h00);
    send_item(REQ_READ, 6'd2, 6'd2, 8'h00);
    send_item(REQ_WRITE, 6'd2, 6'd2, 8'h00);
    send_item(REQ_RUN, 6'd63, 6'd63, 8'hFF);
    send_item(REQ_READ, 6'd1, 6'd2, 8'h00);

    idle_pct = 54;
    setup_frame(7'd0, 7'd0, 7'd1);
    random_items(20, 1'b1);
    setup_frame(7'd1, 7'd127, 7'd2);
    random_items(20, 1'b1);
    idle_pct = 31;
    setup_frame(7'd127, 7'd1, 7'd15);
    random_items(20, 1'b1);
    setup_frame(7'd3, 7'd3, 7'd0);
    random_items(20, 1'b1);
    idle_pct = 0;
    setup_frame(7'd64, 7'd2, 7'd1);
    random_items(20, 1'b0);
    send_item(REQ_RUN, 6'd0, 6'd0, 8'h00);
    send_item(REQ_READ, 6'd63, 6'd63, 8'h00);
    for (int s = 0; s < 4; s++) begin
      idle_pct = phase_pct[s % 4];
      setup_frame(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)),
                  7'($urandom_range(0, 3)));
      random_items(20, 1'b1);
    end
    start <= 1'b0;

    guard = 0;
    while (sb.pending() != 0 && guard < 400000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    $display("Covered %0d beats: %0d pixel writes, %0d reads, %0d thinning runs, %0d flagged.",
             items_sent, sb.n_writes, sb.n_reads, sb.n_runs, sb.n_flagged);
    $display("Frames from 1x1 up to 64 columns or 64 rows with 0 to 15 passes, with and without idle gaps.");
    if (sb.errors == 0) begin
      $display("binary_image_thinning_unit_tb passed");
    end else begin
      $display("binary_image_thinning_unit_tb failed");
    end
    $finish;
  end
endmodule
